FILE: hdl/i2cbe_pkg.sv
package i2cbe_pkg;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_STOP    = 3'd1,
		OP_RESTART = 3'd2,
		OP_WRITE   = 3'd3,
		OP_RXACK   = 3'd4,
		OP_READ    = 3'd5,
		OP_ACK     = 3'd6,
		OP_NACK    = 3'd7
	} op_t;

	// Last sub-tick of a bit slot and last bit of a byte.
	localparam logic [1:0] SUB_LAST = 2'd2;
	localparam logic [2:0] BIT_LAST = 3'd7;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_received;
	} res_t;

endpackage

FILE: hdl/i2cbe_ifs.sv
interface i2cbe_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] opcode;
	logic [7:0] tx_byte;
	logic       sda_in;

	modport source (output valid, cmd_valid, opcode, tx_byte, sda_in, input ready);
	modport sink (input valid, cmd_valid, opcode, tx_byte, sda_in, output ready);
endinterface

interface i2cbe_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_received;

	modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
		ack_received, input ready);
	modport sink (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
		ack_received, output ready);
endinterface

FILE: hdl/i2c_master_bit_engine_unit.sv
// Channel  Modport  Items                 Payload
// tick     sink     one delay tick        cmd_valid, opcode, tx_byte, sda_in
// result   source   one result per tick   scl_level, sda_release, busy_res, done_res,
//                                         rx_byte, ack_received
//
// Every tick item yields one result item: it is first captured in the input register,
// then the line sequencer updates its state and loads the result register.
// One item is taken per cycle, limited only by the result side.
// When the result is not taken, the input register and the result register both hold,
// and tick.ready drops once both are full.
// Reset is asynchronous: SCL and SDA are released, the sequencer goes idle.
module i2c_master_bit_engine_unit (
	input logic          clk,
	input logic          arst_n,
	i2cbe_tick_if.sink   tick,
	i2cbe_res_if.source  result
);

	logic               v_s1;
	i2cbe_pkg::tick_t   tick_s1;
	logic               out_valid_q;
	i2cbe_pkg::res_t    out_q;
	i2cbe_pkg::res_t    res;
	logic               advance;

	// The stage-one item moves on when the result register is empty or being drained.
	assign advance    = !out_valid_q || result.ready;
	assign tick.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.ready) v_s1 <= tick.valid;
			if (advance) out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.cmd_valid <= tick.cmd_valid;
			tick_s1.opcode    <= tick.opcode;
			tick_s1.tx_byte   <= tick.tx_byte;
			tick_s1.sda_in    <= tick.sda_in;
		end
		if (advance && v_s1) out_q <= res;
	end

	i2cbe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && v_s1),
		.tick   (tick_s1),
		.res    (res)
	);

	assign result.valid        = out_valid_q;
	assign result.scl_level    = out_q.scl_level;
	assign result.sda_release  = out_q.sda_release;
	assign result.busy_res     = out_q.busy_res;
	assign result.done_res     = out_q.done_res;
	assign result.rx_byte      = out_q.rx_byte;
	assign result.ack_received = out_q.ack_received;

endmodule

FILE: hdl/i2cbe_core.sv
module i2cbe_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  i2cbe_pkg::tick_t tick,
	output i2cbe_pkg::res_t  res
);

	logic             active_q;
	i2cbe_pkg::op_t   cmd_q;
	logic [1:0]       sub_q;
	logic [2:0]       bit_q;
	logic [7:0]       tx_q;
	logic [7:0]       rx_q;
	logic             scl_q;
	logic             sda_q;
	logic             ack_q;

	logic             start;
	logic             run;
	logic             last;
	i2cbe_pkg::op_t   cmd;
	logic [1:0]       sub;
	logic [2:0]       bidx;
	logic [7:0]       tx;
	logic [7:0]       rx_mid;
	logic             scl_mid;
	logic             sda_mid;
	logic             ack_mid;
	logic             scl_nxt;
	logic             sda_nxt;
	logic             hold_cnt;
	logic [1:0]       sub_nxt;
	logic [2:0]       bit_nxt;

	assign start = !active_q && tick.cmd_valid;
	assign run   = active_q || start;
	assign cmd   = start ? i2cbe_pkg::op_t'(tick.opcode) : cmd_q;
	assign sub   = start ? 2'd0 : sub_q;
	assign bidx  = start ? 3'd0 : bit_q;
	assign tx    = start ? tick.tx_byte : tx_q;

	always_comb begin
		rx_mid   = (start && cmd == i2cbe_pkg::OP_READ) ? 8'd0 : rx_q;
		scl_mid  = scl_q;
		sda_mid  = sda_q;
		ack_mid  = ack_q;
		last     = 1'b0;
		hold_cnt = 1'b0;
		scl_nxt  = 1'b0;
		sda_nxt  = 1'b0;
		if (run) begin
			case (cmd)
				i2cbe_pkg::OP_START: begin
					if (sub == 2'd0) sda_mid = 1'b0;
					else begin
						scl_mid = 1'b0;
						last    = 1'b1;
					end
				end
				i2cbe_pkg::OP_STOP: begin
					if (sub == 2'd0) sda_mid = 1'b0;
					else begin
						scl_mid = 1'b1;
						last    = 1'b1;
					end
				end
				i2cbe_pkg::OP_RESTART: begin
					if (sub == 2'd0) sda_mid = 1'b1;
					else if (sub == 2'd1) scl_mid = 1'b1;
					else begin
						sda_mid = 1'b0;
						last    = 1'b1;
					end
				end
				i2cbe_pkg::OP_WRITE: begin
					if (sub == 2'd0) sda_mid = tx[3'd7 - bidx];
					else if (sub == 2'd1) scl_mid = 1'b1;
					else scl_mid = 1'b0;
					last = (bidx == i2cbe_pkg::BIT_LAST) && (sub == i2cbe_pkg::SUB_LAST);
				end
				i2cbe_pkg::OP_RXACK: begin
					if (sub == 2'd0) sda_mid = 1'b1;
					else if (sub == 2'd1) begin
						scl_mid = 1'b1;
						ack_mid = !tick.sda_in;
						last    = !tick.sda_in;
					end else last = 1'b1;
				end
				i2cbe_pkg::OP_READ: begin
					// The lead-in tick releases SDA and leaves the bit counters at zero.
					if (start) begin
						sda_mid  = 1'b1;
						hold_cnt = 1'b1;
					end else begin
						if (sub == 2'd1) begin
							scl_mid = 1'b1;
							if (tick.sda_in) rx_mid[3'd7 - bidx] = 1'b1;
						end
						last = (bidx == i2cbe_pkg::BIT_LAST) && (sub == i2cbe_pkg::SUB_LAST);
					end
				end
				i2cbe_pkg::OP_ACK, i2cbe_pkg::OP_NACK: begin
					if (sub == 2'd0) sda_mid = (cmd == i2cbe_pkg::OP_NACK);
					else begin
						scl_mid = 1'b1;
						last    = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// Line changes that take effect only after this tick's levels are shown.
		scl_nxt = scl_mid;
		sda_nxt = sda_mid;
		if (run && last) begin
			case (cmd)
				i2cbe_pkg::OP_STOP: sda_nxt = 1'b1;
				i2cbe_pkg::OP_RESTART, i2cbe_pkg::OP_RXACK, i2cbe_pkg::OP_ACK,
				i2cbe_pkg::OP_NACK: scl_nxt = 1'b0;
				default: ;
			endcase
		end
		if (run && cmd == i2cbe_pkg::OP_READ && !start && sub == i2cbe_pkg::SUB_LAST)
			scl_nxt = 1'b0;

		sub_nxt = sub;
		bit_nxt = bidx;
		if (last) begin
			sub_nxt = 2'd0;
			bit_nxt = 3'd0;
		end else if (!hold_cnt) begin
			if (sub == i2cbe_pkg::SUB_LAST) begin
				sub_nxt = 2'd0;
				bit_nxt = bidx + 3'd1;
			end else sub_nxt = sub + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cmd_q    <= i2cbe_pkg::OP_START;
			sub_q    <= 2'd0;
			bit_q    <= 3'd0;
			tx_q     <= 8'd0;
			rx_q     <= 8'd0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			ack_q    <= 1'b0;
		end else if (step && run) begin
			active_q <= !last;
			cmd_q    <= cmd;
			sub_q    <= sub_nxt;
			bit_q    <= bit_nxt;
			tx_q     <= tx;
			rx_q     <= rx_mid;
			scl_q    <= scl_nxt;
			sda_q    <= sda_nxt;
			ack_q    <= ack_mid;
		end
	end

	assign res.scl_level    = scl_mid;
	assign res.sda_release  = sda_mid;
	assign res.busy_res     = run;
	assign res.done_res     = run && last;
	assign res.rx_byte      = rx_mid;
	assign res.ack_received = ack_mid;

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (sub_q == 2'd0 && bit_q == 3'd0))
		else $error("bit counters not cleared while idle");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != 2'd3)
		else $error("sub-tick counter out of range");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> !active_q)
		else $error("sequence still active after its done tick");

endmodule

FILE: verif/i2c_master_bit_engine_unit_tb.sv
module i2c_master_bit_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cbe_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TICK_TARGET = 1550;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTED = 200;

	class line_scoreboard;
		res_t expected_lines[$];
		int   errors;
		int   results_checked;
		int   ops_started[8];
		int   dropped_cmds;
		int   missing_acks;

		logic       seq_active;
		op_t        seq_op;
		logic [4:0] seq_tick;
		logic [7:0] tx_shift;
		logic [7:0] rx_shift;
		logic       scl_q;
		logic       sda_rel_q;
		logic       ack_q;

		function new();
			seq_active = 1'b0;
			seq_op = OP_START;
			seq_tick = '0;
			tx_shift = '0;
			rx_shift = '0;
			scl_q = 1'b1;
			sda_rel_q = 1'b1;
			ack_q = 1'b0;
		endfunction

		function void take_tick(tick_t t);
			res_t       want;
			logic       last;
			logic       scl_fall;
			logic       sda_free;
			logic [4:0] p;
			logic [4:0] q;
			logic [2:0] i;
			logic [1:0] s;

			if (seq_active && t.cmd_valid)
				dropped_cmds++;
			if (!seq_active && t.cmd_valid) begin
				seq_active = 1'b1;
				seq_op = op_t'(t.opcode);
				seq_tick = '0;
				tx_shift = t.tx_byte;
				if (seq_op == OP_READ)
					rx_shift = '0;
				ops_started[seq_op]++;
			end
			want = '0;
			last = 1'b0;
			scl_fall = 1'b0;
			sda_free = 1'b0;
			p = seq_tick;
			if (seq_active) begin
				case (seq_op)
					OP_START: begin
						if (p == 0) begin
							sda_rel_q = 1'b0;
						end else begin
							scl_q = 1'b0;
							last = 1'b1;
						end
					end
					OP_STOP: begin
						if (p == 0) begin
							sda_rel_q = 1'b0;
						end else begin
							scl_q = 1'b1;
							sda_free = 1'b1;
							last = 1'b1;
						end
					end
					OP_RESTART: begin
						if (p == 0) begin
							sda_rel_q = 1'b1;
						end else if (p == 1) begin
							scl_q = 1'b1;
						end else begin
							sda_rel_q = 1'b0;
							scl_fall = 1'b1;
							last = 1'b1;
						end
					end
					OP_WRITE: begin
						i = 3'(p / 5'd3);
						s = 2'(p % 5'd3);
						if (s == 0)
							sda_rel_q = tx_shift[BIT_LAST - i];
						else if (s == 1)
							scl_q = 1'b1;
						else
							scl_q = 1'b0;
						last = (i == BIT_LAST) && (s == SUB_LAST);
					end
					OP_RXACK: begin
						if (p == 0) begin
							sda_rel_q = 1'b1;
						end else if (p == 1) begin
							scl_q = 1'b1;
							ack_q = !t.sda_in;
							// Without an acknowledge SCL stays high one tick longer.
							if (ack_q) begin
								scl_fall = 1'b1;
								last = 1'b1;
							end else begin
								missing_acks++;
							end
						end else begin
							scl_fall = 1'b1;
							last = 1'b1;
						end
					end
					OP_READ: begin
						if (p == 0) begin
							sda_rel_q = 1'b1;
						end else begin
							q = p - 5'd1;
							i = 3'(q / 5'd3);
							s = 2'(q % 5'd3);
							if (s == 1) begin
								scl_q = 1'b1;
								if (t.sda_in)
									rx_shift[BIT_LAST - i] = 1'b1;
							end else if (s == SUB_LAST) begin
								scl_fall = 1'b1;
							end
							last = (i == BIT_LAST) && (s == SUB_LAST);
						end
					end
					default: begin
						if (p == 0) begin
							sda_rel_q = (seq_op == OP_NACK);
						end else begin
							scl_q = 1'b1;
							scl_fall = 1'b1;
							last = 1'b1;
						end
					end
				endcase
				want.busy_res = 1'b1;
				want.done_res = last;
				if (last) begin
					seq_active = 1'b0;
					seq_tick = '0;
				end else begin
					seq_tick = seq_tick + 5'd1;
				end
			end
			// The line levels seen on this tick are the ones held before any
			// change that follows the tick.
			want.scl_level = scl_q;
			want.sda_release = sda_rel_q;
			want.rx_byte = rx_shift;
			want.ack_received = ack_q;
			expected_lines.push_back(want);
			if (scl_fall)
				scl_q = 1'b0;
			if (sda_free)
				sda_rel_q = 1'b1;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("ERROR: %s", msg);
		endtask

		task compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want)
				report($sformatf("result %0d, %s: expected %0h, got %0h",
					results_checked, name, want, got));
		endtask

		task check_lines(res_t got);
			res_t want;

			if (expected_lines.size() == 0) begin
				report("result item arrived with no tick outstanding");
				return;
			end
			want = expected_lines.pop_front();
			results_checked++;
			compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
			compare_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
			compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
			compare_field("rx_byte", want.rx_byte, got.rx_byte);
			compare_field("ack_received", 8'(want.ack_received), 8'(got.ack_received));
		endtask

		task flush_leftovers();
			while (expected_lines.size() != 0) begin
				void'(expected_lines.pop_front());
				report("expected result item never arrived");
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   ticks_sent;
	int   cycle_count;

	i2cbe_tick_if tick_ch();
	i2cbe_res_if  res_ch();

	line_scoreboard sb = new();

	i2c_master_bit_engine_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready)
				sb.take_tick(tick_t'{tick_ch.cmd_valid, tick_ch.opcode, tick_ch.tx_byte,
					tick_ch.sda_in});
			if (res_ch.valid && res_ch.ready)
				sb.check_lines(res_t'{res_ch.scl_level, res_ch.sda_release, res_ch.busy_res,
					res_ch.done_res, res_ch.rx_byte, res_ch.ack_received});
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
			sb.expected_lines.size());
		$display("i2c_master_bit_engine_unit regression: fail");
		$finish;
	end

	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.cmd_valid <= t.cmd_valid;
		tick_ch.opcode <= t.opcode;
		tick_ch.tx_byte <= t.tx_byte;
		tick_ch.sda_in <= t.sda_in;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	task automatic idle_ticks(input int n);
		tick_t t;

		repeat (n) begin
			t = tick_t'(13'($urandom));
			t.cmd_valid = 1'b0;
			send_tick(t);
		end
	endtask

	// Sends one command and then the ticks it keeps the sequencer busy for. For a
	// read, data is the byte the slave presents on SDA; nack leaves the ack slot high.
	task automatic do_command(input op_t op, input logic [7:0] data, input logic nack,
		input int stray_pct);
		tick_t t;
		int    len;
		int    k;
		int    q;

		case (op)
			OP_WRITE:   len = 24;
			OP_READ:    len = 25;
			OP_RESTART: len = 3;
			OP_RXACK:   len = nack ? 3 : 2;
			default:    len = 2;
		endcase
		for (k = 0; k < len; k++) begin
			t = tick_t'(13'($urandom));
			if (k == 0) begin
				t.cmd_valid = 1'b1;
				t.opcode = op;
				t.tx_byte = data;
			end else begin
				t.cmd_valid = ($urandom_range(99) < stray_pct);
			end
			q = k - 1;
			if (op == OP_RXACK && k == 1)
				t.sda_in = nack;
			else if (op == OP_READ && k > 0 && q % 3 == 1)
				t.sda_in = data[BIT_LAST - q / 3];
			send_tick(t);
		end
		if ($urandom_range(3) == 0)
			idle_ticks($urandom_range(1, 3));
	endtask

	task automatic random_transaction();
		logic [7:0] addr;
		int         n;
		int         k;

		addr = 8'($urandom);
		do_command(OP_START, 8'($urandom), 1'b0, 10);
		do_command(OP_WRITE, addr, 1'b0, 10);
		do_command(OP_RXACK, 8'($urandom), $urandom_range(4) == 0, 10);
		if ($urandom_range(3) == 0) begin
			addr = 8'($urandom);
			do_command(OP_RESTART, 8'($urandom), 1'b0, 10);
			do_command(OP_WRITE, addr, 1'b0, 10);
			do_command(OP_RXACK, 8'($urandom), $urandom_range(4) == 0, 10);
		end
		n = $urandom_range(1, 3);
		for (k = 0; k < n; k++) begin
			if (addr[0]) begin
				do_command(OP_READ, 8'($urandom), 1'b0, 10);
				do_command((k == n - 1) ? OP_NACK : OP_ACK, 8'($urandom), 1'b0, 10);
			end else begin
				do_command(OP_WRITE, 8'($urandom), 1'b0, 10);
				do_command(OP_RXACK, 8'($urandom), $urandom_range(4) == 0, 10);
			end
		end
		do_command(OP_STOP, 8'($urandom), 1'b0, 10);
	endtask

	task automatic noise_burst();
		tick_t t;

		repeat ($urandom_range(5, 40)) begin
			t = tick_t'(13'($urandom));
			t.cmd_valid = ($urandom_range(2) == 0);
			send_tick(t);
		end
		// No command runs longer than 25 ticks, so the sequencer is idle after this.
		idle_ticks(28);
	endtask

	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_lines.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int phase;
		int pick;

		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.cmd_valid = 1'b0;
		tick_ch.opcode = OP_START;
		tick_ch.tx_byte = 8'h00;
		tick_ch.sda_in = 1'b1;
		res_ch.ready = 1'b0;
		send_idle_pct = 27;
		recv_idle_pct = 47;
		ticks_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_ticks(2);
		do_command(OP_START, 8'h00, 1'b0, 0);
		// Every busy tick after the first, the done tick included, also carries a command to drop.
		do_command(OP_WRITE, 8'hFF, 1'b0, 100);
		do_command(OP_RXACK, 8'h00, 1'b0, 0);
		do_command(OP_WRITE, 8'h00, 1'b0, 0);
		do_command(OP_RXACK, 8'hFF, 1'b1, 0);
		do_command(OP_RESTART, 8'h00, 1'b0, 0);
		do_command(OP_READ, 8'hFF, 1'b0, 0);
		do_command(OP_ACK, 8'h00, 1'b0, 0);
		do_command(OP_READ, 8'h00, 1'b0, 100);
		do_command(OP_NACK, 8'hFF, 1'b0, 0);
		do_command(OP_STOP, 8'h00, 1'b0, 0);
		// Commands out of protocol order, starting from a stopped bus.
		do_command(OP_READ, 8'h5A, 1'b0, 0);
		do_command(OP_NACK, 8'h00, 1'b0, 0);
		do_command(OP_STOP, 8'h00, 1'b0, 0);
		do_command(OP_STOP, 8'h00, 1'b0, 0);
		do_command(OP_RESTART, 8'h00, 1'b0, 0);
		do_command(OP_RXACK, 8'h00, 1'b1, 100);
		do_command(OP_START, 8'h00, 1'b0, 0);
		wait_drained();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (ticks_sent < TICK_TARGET * (phase + 1) / 3) begin
				pick = $urandom_range(99);
				if (pick < 60)
					random_transaction();
				else if (pick < 85)
					do_command(op_t'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
						10);
				else
					noise_burst();
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_leftovers();
		$display("Sent %0d ticks, checked %0d results, %0d commands dropped while busy, %0d %s",
			ticks_sent, sb.results_checked, sb.dropped_cmds, sb.errors, "mismatches.");
		$display("Started: start %0d stop %0d restart %0d write %0d rx-ack %0d (%0d %s",
			sb.ops_started[OP_START], sb.ops_started[OP_STOP], sb.ops_started[OP_RESTART],
			sb.ops_started[OP_WRITE], sb.ops_started[OP_RXACK], sb.missing_acks,
			$sformatf("unacked) read %0d ack %0d nack %0d.", sb.ops_started[OP_READ],
				sb.ops_started[OP_ACK], sb.ops_started[OP_NACK]));
		if (sb.errors == 0)
			$display("i2c_master_bit_engine_unit regression: pass");
		else
			$display("i2c_master_bit_engine_unit regression: fail");
		$finish;
	end

endmodule
